>>> rtl/bilinear_downscale_bgra_to_rgb_unit_assert.svh
// Assertion macros for the bilinear downscaler.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef BILINEAR_DOWNSCALE_BGRA_TO_RGB_UNIT_ASSERT_SVH
`define BILINEAR_DOWNSCALE_BGRA_TO_RGB_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define BDSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition in one cycle implies a condition in the next
`define BDSC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define BDSC_ASSERT(lbl, prop, msg)
`define BDSC_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> rtl/bdsc_pkg.sv
// Shared constants, types and the tap locator of the bilinear downscaler.
// No dependencies.
package bdsc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ADDR_W     = 12;
  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int SIZE_W     = 13;
  localparam int PH_W       = 36;
  localparam int Q_W        = PH_W - FRAC_BITS;
  localparam int W_W        = FRAC_BITS + 1;
  localparam int HLERP_W    = CH_W + W_W;
  localparam int VLERP_W    = HLERP_W + W_W;

  localparam logic [SIZE_W-1:0] MAX_SRC = 13'd4096;
  localparam logic [SIZE_W-1:0] MAX_DST = 13'd4096;
  localparam logic [SIZE_W-1:0] MIN_SRC = 13'd2;
  localparam logic [W_W-1:0]    ONE_Q   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [PH_W-1:0] HALF_Q = PH_W'(1) << (FRAC_BITS - 1);

  // Far tap index and weight of one sample position
  typedef struct packed {
    logic [ADDR_W-1:0] tap;
    logic [W_W-1:0]    w;
  } loc_t;

  // Clamp at the edges: negative uses tap 1 weight 0, beyond the end tap n-1 weight 1
  function automatic loc_t locate(input logic signed [PH_W-1:0] pos,
                                  input logic [SIZE_W-1:0] n);
    loc_t              r;
    logic [Q_W-1:0]    q;
    logic [SIZE_W-1:0] nm1;
    nm1 = n - 13'd1;
    q   = pos[PH_W-1:FRAC_BITS];
    if (pos[PH_W-1]) begin
      r.tap = 12'd1;
      r.w   = '0;
    end else if ({{(Q_W-SIZE_W){1'b0}}, nm1} <= q) begin
      r.tap = nm1[ADDR_W-1:0];
      r.w   = ONE_Q;
    end else begin
      r.tap = q[ADDR_W-1:0] + 12'd1;
      r.w   = {1'b0, pos[FRAC_BITS-1:0]};
    end
    return r;
  endfunction

endpackage

>>> rtl/bdsc_line_mem.sv
// Line store of the downscaler: one source row of RGB pixels.
// Synchronous single port write, one registered read. Uses bdsc_pkg.
module bdsc_line_mem (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [bdsc_pkg::ADDR_W-1:0]  rd_addr_i,
  output logic [bdsc_pkg::PIX_W-1:0]   rd_data_o,
  input  logic                         wr_en_i,
  input  logic [bdsc_pkg::ADDR_W-1:0]  wr_addr_i,
  input  logic [bdsc_pkg::PIX_W-1:0]   wr_data_i
);

  logic [bdsc_pkg::PIX_W-1:0] line_mem [2**bdsc_pkg::ADDR_W];
  logic [bdsc_pkg::PIX_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      line_mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= line_mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/bdsc_blend.sv
// Two stage bilinear blend of three channels: horizontal lerp registered,
// then vertical lerp with rounding. Uses bdsc_pkg.
module bdsc_blend (
  input  logic                        clk_i,
  input  logic                        h_en_i,
  input  logic [bdsc_pkg::PIX_W-1:0]  up_left_i,
  input  logic [bdsc_pkg::PIX_W-1:0]  up_i,
  input  logic [bdsc_pkg::PIX_W-1:0]  left_i,
  input  logic [bdsc_pkg::PIX_W-1:0]  cur_i,
  input  logic [bdsc_pkg::W_W-1:0]    wx_i,
  input  logic [bdsc_pkg::W_W-1:0]    wy_i,
  output logic [bdsc_pkg::PIX_W-1:0]  rgb_o
);

  logic [bdsc_pkg::HLERP_W-1:0] top_d [3];
  logic [bdsc_pkg::HLERP_W-1:0] bot_d [3];
  logic [bdsc_pkg::HLERP_W-1:0] top_q [3];
  logic [bdsc_pkg::HLERP_W-1:0] bot_q [3];
  logic [bdsc_pkg::W_W-1:0]     wxn;
  logic [bdsc_pkg::W_W-1:0]     wyn;
  logic [bdsc_pkg::VLERP_W-1:0] acc [3];

  assign wxn = bdsc_pkg::ONE_Q - wx_i;
  assign wyn = bdsc_pkg::ONE_Q - wy_i;

  // horizontal lerp of upper and lower tap pairs
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      top_d[k] = bdsc_pkg::HLERP_W'(up_left_i[k*8 +: 8]) * bdsc_pkg::HLERP_W'(wxn)
               + bdsc_pkg::HLERP_W'(up_i[k*8 +: 8]) * bdsc_pkg::HLERP_W'(wx_i);
      bot_d[k] = bdsc_pkg::HLERP_W'(left_i[k*8 +: 8]) * bdsc_pkg::HLERP_W'(wxn)
               + bdsc_pkg::HLERP_W'(cur_i[k*8 +: 8]) * bdsc_pkg::HLERP_W'(wx_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_en_i) begin
      top_q <= top_d;
      bot_q <= bot_d;
    end
  end

  // vertical lerp, round half up
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = bdsc_pkg::VLERP_W'(top_q[k]) * bdsc_pkg::VLERP_W'(wyn)
             + bdsc_pkg::VLERP_W'(bot_q[k]) * bdsc_pkg::VLERP_W'(wy_i)
             + (bdsc_pkg::VLERP_W'(1) << (2*bdsc_pkg::FRAC_BITS - 1));
      rgb_o[k*8 +: 8] = acc[k][2*bdsc_pkg::FRAC_BITS +: bdsc_pkg::CH_W];
    end
  end

endmodule

>>> rtl/bilinear_downscale_bgra_to_rgb_unit.sv
// Bilinear downscaler top level: counters, phase accumulators, sequencer.
// Depends on bdsc_pkg, bdsc_line_mem, bdsc_blend and the assertion header.
//
// Usage: source pixels enter in raster order on the in_* channel
// (valid/stall); frame_start marks source pixel (0,0). Each pixel causes
// zero to four output pixels on the out_* channel (valid/stall), ordered
// by row then column, the last one flagged with last_of_run_o. The size
// and step registers are written through cfg_* (valid/ready, always ready)
// by the user only while the block is idle; the block does not enforce it.
// Sequence: a pixel is taken and its line store read is registered, then
// tap location, then per result a horizontal and a vertical lerp, then
// write back of the line store (S_WR2 on the last column, then S_UPD).
// The input stalls until write back is done, a limit set by the single
// line store port and the shared blend datapath; results leave through
// an output register, so a stalled receiver only holds the sequencer
// when a further result is ready. Reset returns counters, phases, settings
// and state to their defaults; payload and line store are not cleared.
`include "bilinear_downscale_bgra_to_rgb_unit_assert.svh"
module bilinear_downscale_bgra_to_rgb_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  red_in_i,
  input  logic        frame_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [11:0] out_col_o,
  output logic [11:0] out_row_o,
  output logic        last_of_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [21:0] cfg_data_i
);

  localparam int PH_W   = bdsc_pkg::PH_W;
  localparam int SIZE_W = bdsc_pkg::SIZE_W;
  localparam int ADDR_W = bdsc_pkg::ADDR_W;
  localparam int PIX_W  = bdsc_pkg::PIX_W;
  localparam int W_W    = bdsc_pkg::W_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOC  = 3'd1;
  localparam logic [2:0] S_HORZ = 3'd2;
  localparam logic [2:0] S_VERT = 3'd3;
  localparam logic [2:0] S_WR2  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;

  localparam logic [2:0] REG_SRC_W  = 3'd0;
  localparam logic [2:0] REG_SRC_H  = 3'd1;
  localparam logic [2:0] REG_DST_W  = 3'd2;
  localparam logic [2:0] REG_DST_H  = 3'd3;
  localparam logic [2:0] REG_XSTEP  = 3'd4;
  localparam logic [2:0] REG_YSTEP  = 3'd5;

  // configuration
  logic [SIZE_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic [20:0]       x_step_q;
  logic [21:0]       y_step_q;

  // control state
  logic [2:0]               state_q;
  logic [ADDR_W-1:0]        src_col_q, src_row_q;
  logic [SIZE_W-1:0]        next_out_col_q, next_out_row_q;
  logic signed [PH_W-1:0]   col_phase_q, row_phase_q;
  logic [PIX_W-1:0]         left_q, prev_up_q;
  logic [1:0]               ncol_q, nrow_q, used_q, radv_q;
  logic                     ci_q, ri_q;
  logic                     out_valid_q;

  // per pixel payload
  logic [PIX_W-1:0]         cur_q;
  logic [ADDR_W-1:0]        col_x_q [2];
  logic [ADDR_W-1:0]        row_y_q [2];
  logic [W_W-1:0]           col_w_q [2];
  logic [W_W-1:0]           row_w_q [2];
  logic signed [PH_W-1:0]   cp1_q, rp1_q;
  logic [7:0]               red_q, green_q, blue_q;
  logic [11:0]              ocol_q, orow_q;
  logic                     olast_q;

  // derived
  logic [SIZE_W-1:0]        sw, sh, dw, dh;
  logic signed [PH_W-1:0]   col_init, row_init, cp1, rp1;
  bdsc_pkg::loc_t           lc0, lc1, lr0, lr1;
  logic [SIZE_W-1:0]        x0, x1, y0, y1;
  logic                     cok0, cok1, rok0, rok1, ch0, ch1, rh0, rh1;
  logic                     in_accept, out_load, last_col, last_res;
  logic [PIX_W-1:0]         up_pix, blend_rgb;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr, rd_addr;
  logic [PIX_W-1:0]         mem_wdata;
  logic [SIZE_W-1:0]        row_next;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  // effective sizes
  always_comb begin
    sw = (src_width_q < bdsc_pkg::MIN_SRC) ? bdsc_pkg::MIN_SRC :
         (src_width_q > bdsc_pkg::MAX_SRC) ? bdsc_pkg::MAX_SRC : src_width_q;
    sh = (src_height_q < bdsc_pkg::MIN_SRC) ? bdsc_pkg::MIN_SRC :
         (src_height_q > bdsc_pkg::MAX_SRC) ? bdsc_pkg::MAX_SRC : src_height_q;
    dw = (dst_width_q > bdsc_pkg::MAX_DST) ? bdsc_pkg::MAX_DST : dst_width_q;
    dh = (dst_height_q > bdsc_pkg::MAX_DST) ? bdsc_pkg::MAX_DST : dst_height_q;
  end

  assign col_init = PH_W'(x_step_q >> 1) - bdsc_pkg::HALF_Q;
  assign row_init = PH_W'(y_step_q >> 1) - bdsc_pkg::HALF_Q;
  assign cp1      = col_phase_q + PH_W'(x_step_q);
  assign rp1      = row_phase_q + PH_W'(y_step_q);

  // tap location for two columns and two rows
  always_comb begin
    lc0  = bdsc_pkg::locate(col_phase_q, sw);
    lc1  = bdsc_pkg::locate(cp1, sw);
    lr0  = bdsc_pkg::locate(row_phase_q, sh);
    lr1  = bdsc_pkg::locate(rp1, sh);
    x0   = next_out_col_q;
    x1   = next_out_col_q + 13'd1;
    y0   = next_out_row_q;
    y1   = next_out_row_q + 13'd1;
    cok0 = (x0 < dw) && (lc0.tap <= src_col_q);
    cok1 = cok0 && (x1 < dw) && (lc1.tap <= src_col_q);
    rok0 = (y0 < dh) && (lr0.tap <= src_row_q);
    rok1 = rok0 && (y1 < dh) && (lr1.tap <= src_row_q);
    ch0  = cok0 && (lc0.tap == src_col_q);
    ch1  = cok1 && (lc1.tap == src_col_q);
    rh0  = rok0 && (lr0.tap == src_row_q);
    rh1  = rok1 && (lr1.tap == src_row_q);
  end

  assign last_col = ({1'b0, src_col_q} + 13'd1) >= sw;
  assign row_next = {1'b0, src_row_q} + 13'd1;
  assign last_res = ({1'b0, ri_q} == nrow_q - 2'd1) && ({1'b0, ci_q} == ncol_q - 2'd1);
  assign out_load = (state_q == S_VERT) && (!out_valid_q || !out_stall_i);

  // line store write back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = src_col_q;
    mem_wdata = cur_q;
    if (state_q == S_WR2) begin
      mem_we = 1'b1;
    end else if (state_q == S_UPD) begin
      mem_we    = (src_col_q != '0);
      mem_waddr = src_col_q - 12'd1;
      mem_wdata = left_q;
    end
  end

  assign rd_addr = frame_start_i ? '0 : src_col_q;

  bdsc_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (up_pix),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata)
  );

  bdsc_blend u_blend (
    .clk_i     (clk_i),
    .h_en_i    (state_q == S_HORZ),
    .up_left_i (prev_up_q),
    .up_i      (up_pix),
    .left_i    (left_q),
    .cur_i     (cur_q),
    .wx_i      (col_w_q[ci_q]),
    .wy_i      (row_w_q[ri_q]),
    .rgb_o     (blend_rgb)
  );

  // sequencer, counters and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q    <= 13'd1920;
      src_height_q   <= 13'd1080;
      dst_width_q    <= 13'd1280;
      dst_height_q   <= 13'd720;
      x_step_q       <= 21'd98304;
      y_step_q       <= 22'd98304;
      state_q        <= S_IDLE;
      src_col_q      <= '0;
      src_row_q      <= '0;
      next_out_col_q <= '0;
      next_out_row_q <= '0;
      col_phase_q    <= PH_W'(98304 / 2) - bdsc_pkg::HALF_Q;
      row_phase_q    <= PH_W'(98304 / 2) - bdsc_pkg::HALF_Q;
      left_q         <= '0;
      prev_up_q      <= '0;
      ncol_q         <= '0;
      nrow_q         <= '0;
      used_q         <= '0;
      radv_q         <= '0;
      ci_q           <= 1'b0;
      ri_q           <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_SRC_W: src_width_q  <= cfg_data_i[SIZE_W-1:0];
          REG_SRC_H: src_height_q <= cfg_data_i[SIZE_W-1:0];
          REG_DST_W: dst_width_q  <= cfg_data_i[SIZE_W-1:0];
          REG_DST_H: dst_height_q <= cfg_data_i[SIZE_W-1:0];
          REG_XSTEP: x_step_q     <= cfg_data_i[20:0];
          REG_YSTEP: y_step_q     <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_LOC;
            if (frame_start_i) begin
              src_col_q      <= '0;
              src_row_q      <= '0;
              next_out_col_q <= '0;
              next_out_row_q <= '0;
              col_phase_q    <= col_init;
              row_phase_q    <= row_init;
            end
          end
        end
        S_LOC: begin
          ncol_q <= {1'b0, ch0} + {1'b0, ch1};
          nrow_q <= {1'b0, rh0} + {1'b0, rh1};
          used_q <= {1'b0, cok0} + {1'b0, cok1};
          radv_q <= {1'b0, rok0} + {1'b0, rok1};
          ci_q   <= 1'b0;
          ri_q   <= 1'b0;
          if ((ch0 || ch1) && (rh0 || rh1)) begin
            state_q <= S_HORZ;
          end else begin
            state_q <= last_col ? S_WR2 : S_UPD;
          end
        end
        S_HORZ: begin
          state_q <= S_VERT;
        end
        S_VERT: begin
          if (out_load) begin
            if (last_res) begin
              state_q <= last_col ? S_WR2 : S_UPD;
            end else begin
              state_q <= S_HORZ;
              if ({1'b0, ci_q} == ncol_q - 2'd1) begin
                ci_q <= 1'b0;
                ri_q <= 1'b1;
              end else begin
                ci_q <= 1'b1;
              end
            end
          end
        end
        S_WR2: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          state_q   <= S_IDLE;
          left_q    <= cur_q;
          prev_up_q <= up_pix;
          if (last_col) begin
            src_col_q      <= '0;
            next_out_col_q <= '0;
            col_phase_q    <= col_init;
            if (row_next >= sh) begin
              src_row_q      <= '0;
              next_out_row_q <= '0;
              row_phase_q    <= row_init;
            end else begin
              src_row_q      <= row_next[ADDR_W-1:0];
              next_out_row_q <= next_out_row_q + SIZE_W'(radv_q);
              case (radv_q)
                2'd1:    row_phase_q <= rp1_q;
                2'd2:    row_phase_q <= rp1_q + PH_W'(y_step_q);
                default: row_phase_q <= row_phase_q;
              endcase
            end
          end else begin
            src_col_q      <= src_col_q + 12'd1;
            next_out_col_q <= next_out_col_q + SIZE_W'(used_q);
            case (used_q)
              2'd1:    col_phase_q <= cp1_q;
              2'd2:    col_phase_q <= cp1_q + PH_W'(x_step_q);
              default: col_phase_q <= col_phase_q;
            endcase
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cur_q <= {red_in_i, green_in_i, blue_in_i};
    end
    if (state_q == S_LOC) begin
      cp1_q      <= cp1;
      rp1_q      <= rp1;
      col_x_q[0] <= ch0 ? x0[ADDR_W-1:0] : x1[ADDR_W-1:0];
      col_w_q[0] <= ch0 ? lc0.w : lc1.w;
      col_x_q[1] <= x1[ADDR_W-1:0];
      col_w_q[1] <= lc1.w;
      row_y_q[0] <= rh0 ? y0[ADDR_W-1:0] : y1[ADDR_W-1:0];
      row_w_q[0] <= rh0 ? lr0.w : lr1.w;
      row_y_q[1] <= y1[ADDR_W-1:0];
      row_w_q[1] <= lr1.w;
    end
    if (out_load) begin
      red_q   <= blend_rgb[23:16];
      green_q <= blend_rgb[15:8];
      blue_q  <= blend_rgb[7:0];
      ocol_q  <= col_x_q[ci_q];
      orow_q  <= row_y_q[ri_q];
      olast_q <= last_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_out_o     = red_q;
  assign green_out_o   = green_q;
  assign blue_out_o    = blue_q;
  assign out_col_o     = ocol_q;
  assign out_row_o     = orow_q;
  assign last_of_run_o = olast_q;

  `BDSC_ASSERT_NEXT(a_accept_loc, in_accept, state_q == S_LOC, "accept not followed by locate")
  `BDSC_ASSERT(a_wr_state, mem_we |-> (state_q == S_WR2 || state_q == S_UPD), "stray store write")
  `BDSC_ASSERT(a_out_free, out_load |-> (!out_valid_q || !out_stall_i), "output overwritten")
  `BDSC_ASSERT(a_emit_idx, (state_q == S_VERT) |-> ({1'b0, ri_q} < nrow_q && {1'b0, ci_q} < ncol_q), "result index out of range")

endmodule
